// ----- hdl/ffa_pkg.sv -----
// Shared types and codes for the first-fit free-list allocator.
// No dependencies; imported by ffa_table and first_fit_free_list_allocator.
package ffa_pkg;

    localparam int DEF_TABLE_ENTRIES = 256;

    // Item kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_LOST = 2'd2;

    // One free-region entry
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } entry_t;

endpackage

// ----- hdl/ffa_table.sv -----
// Free-region table: one write port, one registered read port.
// Depends on ffa_pkg (entry_t).
module ffa_table #(
    parameter int DEPTH = ffa_pkg::DEF_TABLE_ENTRIES,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  ffa_pkg::entry_t       wdata,
    input  logic [IDX_W-1:0]      raddr,
    output ffa_pkg::entry_t       rdata
);
    import ffa_pkg::*;

    entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/first_fit_free_list_allocator.sv -----
// First-fit free-list allocator with coalescing: sequencer, counters, result register.
// Depends on ffa_pkg and ffa_table.
//
//  channel | valid     | stall      | payload
//  --------+-----------+------------+-------------------------------------------------
//  in      | in_valid  | in_stall   | kind, region_addr, region_len
//  out     | out_valid | out_stall  | granted_addr, status, free_bytes, entries_used,
//          |           |            | peak_entries, lost_regions, lost_bytes
//
// One item at a time. The table is walked through its single read port: a scan
// up to the matching entry, then a shift of the tail entries, each read and then
// written, when an entry is removed or inserted. Reset clears the state and the
// counters only; the table needs no clearing. in_stall is high from a transfer in
// until the result transfers out.
module first_fit_free_list_allocator #(
    parameter int TABLE_ENTRIES = ffa_pkg::DEF_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] region_addr,
    input  logic [31:0] region_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] granted_addr,
    output logic [1:0]  status,
    output logic [31:0] free_bytes,
    output logic [8:0]  entries_used,
    output logic [8:0]  peak_entries,
    output logic [31:0] lost_regions,
    output logic [31:0] lost_bytes
);
    import ffa_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_CK = 4'd2;
    localparam logic [3:0] S_FDEC    = 4'd3;
    localparam logic [3:0] S_DN_RD   = 4'd4;
    localparam logic [3:0] S_DN_WR   = 4'd5;
    localparam logic [3:0] S_UP_RD   = 4'd6;
    localparam logic [3:0] S_UP_WR   = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0] idx_reg, idx_next;     // scan position
    logic [CNT_W-1:0] k_reg, k_next;         // shift position
    logic [31:0]      total_reg, total_next;
    logic [31:0]      lcnt_reg, lcnt_next;
    logic [31:0]      lbytes_reg, lbytes_next;
    logic [31:0]      grant_reg, grant_next;
    logic [1:0]       status_reg, status_next;
    logic             kind_reg, kind_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      len_reg, len_next;
    entry_t           prev_reg, prev_next;
    entry_t           cur_reg, cur_next;
    logic             cur_ok_reg, cur_ok_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
    entry_t           rdata;

    logic [32:0]      sat_cnt, sat_bytes;
    logic             prev_touch, cur_touch;
    logic [CNT_W-1:0] idx_m1;

    ffa_table #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Merge and saturation helpers
    assign idx_m1     = idx_reg - CNT_W'(1);
    assign prev_touch = (idx_reg != '0) && (prev_reg.start + prev_reg.len == addr_reg);
    assign cur_touch  = cur_ok_reg && (addr_reg + len_reg == cur_reg.start);
    assign sat_cnt    = {1'b0, lcnt_reg} + 33'd1;
    assign sat_bytes  = {1'b0, lbytes_reg} + {1'b0, len_reg};

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        peak_next   = peak_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        total_next  = total_reg;
        lcnt_next   = lcnt_reg;
        lbytes_next = lbytes_reg;
        grant_next  = grant_reg;
        status_next = status_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        cur_ok_next = cur_ok_reg;
        we          = 1'b0;
        waddr       = idx_reg[IDX_W-1:0];
        wdata       = rdata;
        raddr       = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind;
                    addr_next   = region_addr;
                    len_next    = region_len;
                    idx_next    = '0;
                    grant_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_SCAN_RD;
                end
            end

            // Issue the read of entry idx, or finish the scan at the end
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        status_next = ST_FAIL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cur_ok_next = 1'b0;
                        state_next  = S_FDEC;
                    end
                end
                else
                begin
                    state_next = S_SCAN_CK;
                end
            end

            // Test the entry just read
            S_SCAN_CK:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (rdata.len >= len_reg)
                    begin
                        grant_next  = rdata.start;
                        total_next  = total_reg - len_reg;
                        if (rdata.len == len_reg)
                        begin
                            k_next     = idx_reg;
                            state_next = S_DN_RD;
                        end
                        else
                        begin
                            we         = 1'b1;
                            wdata      = '{start: rdata.start + len_reg,
                                           len:   rdata.len - len_reg};
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else if (rdata.start > addr_reg)
                begin
                    cur_next    = rdata;
                    cur_ok_next = 1'b1;
                    state_next  = S_FDEC;
                end
                else
                begin
                    prev_next  = rdata;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            // Free: merge, insert or drop
            S_FDEC:
            begin
                if (prev_touch)
                begin
                    we         = 1'b1;
                    waddr      = idx_m1[IDX_W-1:0];
                    total_next = total_reg + len_reg;
                    if (cur_touch)
                    begin
                        wdata      = '{start: prev_reg.start,
                                       len:   prev_reg.len + len_reg + cur_reg.len};
                        k_next     = idx_reg;
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        wdata      = '{start: prev_reg.start, len: prev_reg.len + len_reg};
                        state_next = S_DONE;
                    end
                end
                else if (cur_touch)
                begin
                    we         = 1'b1;
                    wdata      = '{start: addr_reg, len: cur_reg.len + len_reg};
                    total_next = total_reg + len_reg;
                    state_next = S_DONE;
                end
                else if (count_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    k_next     = count_reg;
                    state_next = S_UP_RD;
                end
                else
                begin
                    status_next = ST_LOST;
                    lcnt_next   = sat_cnt[32] ? '1 : sat_cnt[31:0];
                    lbytes_next = sat_bytes[32] ? '1 : sat_bytes[31:0];
                    state_next  = S_DONE;
                end
            end

            // Remove entry: move the tail down one place
            S_DN_RD:
            begin
                raddr = idx_reg[IDX_W-1:0] + IDX_W'(1);
                if ({1'b0, k_reg} + {{CNT_W{1'b0}}, 1'b1} < {1'b0, count_reg})
                begin
                    raddr      = k_reg[IDX_W-1:0] + IDX_W'(1);
                    state_next = S_DN_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DN_WR:
            begin
                we         = 1'b1;
                waddr      = k_reg[IDX_W-1:0];
                k_next     = k_reg + CNT_W'(1);
                state_next = S_DN_RD;
            end

            // Insert entry: move the tail up one place, then write the hole
            S_UP_RD:
            begin
                raddr = k_reg[IDX_W-1:0] - IDX_W'(1);
                if (k_reg > idx_reg)
                begin
                    state_next = S_UP_WR;
                end
                else
                begin
                    we         = 1'b1;
                    wdata      = '{start: addr_reg, len: len_reg};
                    total_next = total_reg + len_reg;
                    count_next = count_reg + CNT_W'(1);
                    if (peak_reg < count_reg + CNT_W'(1))
                    begin
                        peak_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_UP_WR:
            begin
                we         = 1'b1;
                waddr      = k_reg[IDX_W-1:0];
                k_next     = k_reg - CNT_W'(1);
                state_next = S_UP_RD;
            end

            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            peak_reg   <= '0;
            total_reg  <= '0;
            lcnt_reg   <= '0;
            lbytes_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            peak_reg   <= peak_next;
            total_reg  <= total_next;
            lcnt_reg   <= lcnt_next;
            lbytes_reg <= lbytes_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        grant_reg  <= grant_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        len_reg    <= len_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        cur_ok_reg <= cur_ok_next;
    end

    // Ports
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = (state_reg == S_DONE);
    assign granted_addr = grant_reg;
    assign status       = status_reg;
    assign free_bytes   = total_reg;
    assign entries_used = 9'(count_reg);
    assign peak_entries = 9'(peak_reg);
    assign lost_regions = lcnt_reg;
    assign lost_bytes   = lbytes_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table depth");

    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= count_reg)
        else $error("peak below current count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg != ST_OK) |-> grant_reg == '0)
        else $error("nonzero grant with failure status");

    a_free_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind_reg == KIND_FREE) |-> grant_reg == '0)
        else $error("grant reported for a free");

endmodule
